[design/modbus_rtu_response_parser_defines.svh]
// assertion macros for the modbus rtu response parser
`ifndef MODBUS_RTU_RESPONSE_PARSER_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_PARSER_DEFINES_SVH

// same-cycle implication, checked on clk_i while out of reset
`define MRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk_i while out of reset
`define MRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mrp_pkg.sv]
// shared types, constants and crc helper for the modbus rtu response parser
`timescale 1ns / 1ps
package mrp_pkg;

  localparam int MIRROR_DEPTH_DEF = 256;
  localparam int MAX_FRAME_DEF    = 256;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FC_READ_HOLD  = 8'h03;
  localparam logic [7:0] FC_READ_INPUT = 8'h04;
  localparam logic [7:0] FC_WRITE_ONE  = 8'h06;
  localparam logic [7:0] FC_WRITE_MANY = 8'h10;

  // frame status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_UNKNOWN   = 3'd2;
  localparam logic [2:0] ST_CRC       = 3'd3;
  localparam logic [2:0] ST_NO_REQ    = 3'd4;
  localparam logic [2:0] ST_COUNT     = 3'd5;
  localparam logic [2:0] ST_RANGE     = 3'd6;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_PEND   = 2'd1,
    OP_RDIN   = 2'd2,
    OP_RDHOLD = 2'd3
  } op_e;

  // one classified request between front and back
  typedef struct packed {
    op_e         op;
    logic        last;
    logic [7:0]  rx_byte;
    logic [7:0]  pfc;
    logic [15:0] pstart;
    logic [15:0] pcount;
    logic [15:0] qaddr;
    logic        in_range;
  } cmd_t;

  // one byte of crc-16/modbus, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

[design/mrp_ram.sv]
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module mrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/mrp_front.sv]
// front end: decodes incoming requests into queue commands
`timescale 1ns / 1ps
module mrp_front #(
  parameter int MIRROR_DEPTH = mrp_pkg::MIRROR_DEPTH_DEF
) (
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mrp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [1:0]                        s_axis_tuser,
  input  logic                              s_axis_tlast,
  input  logic                              q_full_i,
  input  logic                              clr_busy_i,
  output logic                              push_o,
  output mrp_pkg::cmd_t                     cmd_o
);
  import mrp_pkg::*;

  localparam logic [16:0] MD_LIM = 17'(MIRROR_DEPTH);

  // accept when there is room and the mirrors are not being cleared
  assign s_axis_tready = !q_full_i && !clr_busy_i;
  assign push_o        = s_axis_tvalid && s_axis_tready;

  // classify request and pre-check the query address
  always_comb begin
    cmd_o.op       = op_e'(s_axis_tuser);
    cmd_o.last     = s_axis_tlast && (op_e'(s_axis_tuser) == OP_BYTE);
    cmd_o.rx_byte  = s_axis_tdata[7:0];
    cmd_o.pfc      = s_axis_tdata[15:8];
    cmd_o.pstart   = s_axis_tdata[31:16];
    cmd_o.pcount   = s_axis_tdata[47:32];
    cmd_o.qaddr    = s_axis_tdata[63:48];
    cmd_o.in_range = {1'b0, s_axis_tdata[63:48]} < MD_LIM;
  end

endmodule

[design/mrp_queue.sv]
// two-entry command queue between front and back
`timescale 1ns / 1ps
module mrp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mrp_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output mrp_pkg::cmd_t head_o,
  output logic          empty_o
);
  import mrp_pkg::*;

  cmd_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = ent_q[rp_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= cmd_i;
  end

endmodule

[design/mrp_back.sv]
// back end: frame buffer, crc check, mirror commit and register reads
`timescale 1ns / 1ps
module mrp_back #(
  parameter int MIRROR_DEPTH = mrp_pkg::MIRROR_DEPTH_DEF,
  parameter int MAX_FRAME    = mrp_pkg::MAX_FRAME_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mrp_pkg::cmd_t                  head_i,
  input  logic                           empty_i,
  output logic                           pop_o,
  output logic                           clr_busy_o,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [mrp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tuser
);
  import mrp_pkg::*;

  localparam int MAW = (MIRROR_DEPTH > 1) ? $clog2(MIRROR_DEPTH) : 1;
  localparam int FAW = $clog2(MAX_FRAME);
  localparam logic [16:0] MD_LIM = 17'(MIRROR_DEPTH);
  localparam logic [8:0]  MF_LIM = 9'(MAX_FRAME);
  localparam logic [MAW-1:0] CLR_LAST = MAW'(MIRROR_DEPTH - 1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RDOUT = 4'd2;
  localparam logic [3:0] S_PARSE = 4'd3;
  localparam logic [3:0] S_CRC_A = 4'd4;
  localparam logic [3:0] S_CRC_B = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_CM_A  = 4'd7;
  localparam logic [3:0] S_CM_B  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // control registers
  logic [3:0]     state_q, state_d;
  logic [8:0]     bcnt_q, bcnt_d;
  logic           pv_q, pv_d;
  logic [7:0]     pcode_q, pcode_d;
  logic [15:0]    pfirst_q, pfirst_d;
  logic [15:0]    pnum_q, pnum_d;
  logic [MAW-1:0] clr_q, clr_d;
  logic           ov_q, ov_d;

  // payload registers
  logic [8:0]     len_q, len_d;
  logic [7:0]     hdr_q [6];
  logic [7:0]     hdr_d [6];
  logic [8:0]     idx_q, idx_d;
  logic [8:0]     body_q, body_d;
  logic [15:0]    crc_q, crc_d;
  logic [7:0]     crclo_q, crclo_d, crchi_q, crchi_d, hi_q, hi_d;
  logic [2:0]     st_q, st_d;
  logic           rin_q, rin_d, rsel_q, rsel_d;
  logic [OUT_TDATA_W-1:0] od_q, od_d;
  logic           ou_q, ou_d;

  // memory ports
  logic           f_we;
  logic [FAW-1:0] f_waddr, f_raddr;
  logic [7:0]     f_rdata;
  logic           mi_we, mh_we;
  logic [MAW-1:0] m_waddr, m_raddr;
  logic [15:0]    m_wdata, mi_rdata, mh_rdata;

  // parse helpers
  logic [7:0]  fc;
  logic        is_rd, is_wr;
  logic [8:0]  body_c;
  logic [9:0]  need_c;
  logic [15:0] wr_reg;
  logic [16:0] end_c;

  assign fc     = hdr_q[1];
  assign is_rd  = (fc == FC_READ_HOLD) || (fc == FC_READ_INPUT);
  assign is_wr  = (fc == FC_WRITE_ONE) || (fc == FC_WRITE_MANY);
  assign body_c = is_rd ? (9'd3 + {1'b0, hdr_q[2]}) : 9'd6;
  assign need_c = {1'b0, body_c} + 10'd2;
  assign wr_reg = {hdr_q[2], hdr_q[3]};
  assign end_c  = {1'b0, pfirst_q} + {10'b0, hdr_q[2][7:1]};

  assign clr_busy_o    = state_q == S_CLR;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = ou_q;

  mrp_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_frame (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(head_i.rx_byte),
    .raddr_i(f_raddr), .rdata_o(f_rdata)
  );
  mrp_ram #(.WIDTH(16), .DEPTH(MIRROR_DEPTH)) u_in_mirror (
    .clk_i, .we_i(mi_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(mi_rdata)
  );
  mrp_ram #(.WIDTH(16), .DEPTH(MIRROR_DEPTH)) u_hold_mirror (
    .clk_i, .we_i(mh_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(mh_rdata)
  );

  // sequencer
  always_comb begin
    state_d = state_q; bcnt_d = bcnt_q; pv_d = pv_q; pcode_d = pcode_q;
    pfirst_d = pfirst_q; pnum_d = pnum_q; clr_d = clr_q; ov_d = ov_q;
    len_d = len_q; hdr_d = hdr_q; idx_d = idx_q; body_d = body_q; crc_d = crc_q;
    crclo_d = crclo_q; crchi_d = crchi_q; hi_d = hi_q; st_d = st_q;
    rin_d = rin_q; rsel_d = rsel_q; od_d = od_q; ou_d = ou_q;
    pop_o = 1'b0;
    f_we = 1'b0; f_waddr = bcnt_q[FAW-1:0]; f_raddr = idx_q[FAW-1:0];
    mi_we = 1'b0; mh_we = 1'b0; m_waddr = clr_q; m_wdata = 16'h0000;
    m_raddr = head_i.qaddr[MAW-1:0];

    if (ov_q && m_axis_tready) ov_d = 1'b0;

    case (state_q)
      // zero both mirrors, one entry per cycle
      S_CLR: begin
        mi_we = 1'b1;
        mh_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == CLR_LAST) state_d = S_IDLE;
      end
      // take one command while the result slot is free or draining
      S_IDLE: begin
        if (!empty_i && (!ov_q || m_axis_tready)) begin
          pop_o = 1'b1;
          case (head_i.op)
            OP_BYTE: begin
              if (bcnt_q < MF_LIM) begin
                f_we   = 1'b1;
                bcnt_d = bcnt_q + 9'd1;
                if (bcnt_q < 9'd6) hdr_d[bcnt_q[2:0]] = head_i.rx_byte;
              end
              if (head_i.last) begin
                len_d   = bcnt_d;
                bcnt_d  = 9'd0;
                state_d = S_PARSE;
              end
            end
            OP_PEND: begin
              pv_d     = 1'b1;
              pcode_d  = head_i.pfc;
              pfirst_d = head_i.pstart;
              pnum_d   = head_i.pcount;
            end
            default: begin
              rin_d   = head_i.in_range;
              rsel_d  = head_i.op == OP_RDIN;
              state_d = S_RDOUT;
            end
          endcase
        end
      end
      // register read result
      S_RDOUT: begin
        ov_d = 1'b1;
        ou_d = 1'b1;
        od_d = '0;
        if (rin_q) od_d[34:19] = rsel_q ? mi_rdata : mh_rdata;
        state_d = S_IDLE;
      end
      // length and function code checks
      S_PARSE: begin
        state_d = S_DONE;
        if (len_q < 9'd2) st_d = ST_SHORT;
        else if (is_rd && len_q < 9'd3) st_d = ST_SHORT;
        else if (!is_rd && !is_wr) st_d = ST_UNKNOWN;
        else if ({1'b0, len_q} < need_c) st_d = ST_SHORT;
        else begin
          body_d  = body_c;
          idx_d   = 9'd0;
          crc_d   = CRC_INIT;
          state_d = S_CRC_A;
        end
      end
      // crc over body, then pick up the sent crc
      S_CRC_A: state_d = S_CRC_B;
      S_CRC_B: begin
        if (idx_q < body_q) crc_d = crc_byte(crc_q, f_rdata);
        else if (idx_q == body_q) crclo_d = f_rdata;
        else crchi_d = f_rdata;
        idx_d = idx_q + 9'd1;
        state_d = (idx_q == body_q + 9'd1) ? S_CHECK : S_CRC_A;
      end
      // crc and request match checks
      S_CHECK: begin
        state_d = S_DONE;
        st_d    = ST_OK;
        if ({crchi_q, crclo_q} != crc_q) st_d = ST_CRC;
        else if (is_rd) begin
          if (!pv_q || pcode_q != fc) st_d = ST_NO_REQ;
          else if (hdr_q[2][0] || {9'h000, hdr_q[2][7:1]} != pnum_q) st_d = ST_COUNT;
          else if (end_c > MD_LIM) st_d = ST_RANGE;
          else begin
            pv_d  = 1'b0;
            idx_d = 9'd0;
            if (hdr_q[2] != 8'h00) state_d = S_CM_A;
          end
        end else begin
          pv_d = 1'b0;
          if (fc == FC_WRITE_ONE && {1'b0, wr_reg} < MD_LIM) begin
            mh_we   = 1'b1;
            m_waddr = wr_reg[MAW-1:0];
            m_wdata = {hdr_q[4], hdr_q[5]};
          end
        end
      end
      // commit big-endian words, two bytes per word
      S_CM_A: begin
        f_raddr = FAW'(idx_q + 9'd3);
        state_d = S_CM_B;
      end
      S_CM_B: begin
        if (!idx_q[0]) hi_d = f_rdata;
        else begin
          m_waddr = MAW'(pfirst_q + {8'h00, idx_q[8:1]});
          m_wdata = {hi_q, f_rdata};
          if (fc == FC_READ_INPUT) mi_we = 1'b1;
          else mh_we = 1'b1;
        end
        idx_d   = idx_q + 9'd1;
        state_d = (idx_q == {1'b0, hdr_q[2]} - 9'd1) ? S_DONE : S_CM_A;
      end
      // frame status result
      S_DONE: begin
        ov_d = 1'b1;
        ou_d = 1'b0;
        od_d = '0;
        od_d[2:0] = st_q;
        if (len_q >= 9'd1) od_d[10:3] = hdr_q[0];
        if (len_q >= 9'd2) od_d[18:11] = hdr_q[1];
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      bcnt_q   <= 9'd0;
      pv_q     <= 1'b0;
      pcode_q  <= 8'h00;
      pfirst_q <= 16'h0000;
      pnum_q   <= 16'h0000;
      clr_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      bcnt_q   <= bcnt_d;
      pv_q     <= pv_d;
      pcode_q  <= pcode_d;
      pfirst_q <= pfirst_d;
      pnum_q   <= pnum_d;
      clr_q    <= clr_d;
      ov_q     <= ov_d;
    end
  end

  // payload state
  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    hdr_q   <= hdr_d;
    idx_q   <= idx_d;
    body_q  <= body_d;
    crc_q   <= crc_d;
    crclo_q <= crclo_d;
    crchi_q <= crchi_d;
    hi_q    <= hi_d;
    st_q    <= st_d;
    rin_q   <= rin_d;
    rsel_q  <= rsel_d;
    od_q    <= od_d;
    ou_q    <= ou_d;
  end

endmodule

[design/modbus_rtu_response_parser.sv]
// top level of the modbus rtu master response parser
//
// channel  direction  tdata                                            tuser     tlast
// s_axis   in         rx_byte, pending_func_code, pending_start,       req_type  frame_end
//                     pending_count, query_addr
// m_axis   out        frame_status, slave_addr, func_seen, reg_value   result_kind  -
//
// a byte without frame end and a set-request are taken in the idle state of the back end
// a register read goes through S_RDOUT; a frame end rejected on length or code goes
// through S_PARSE to S_DONE, otherwise also through the crc pass and any data byte commit
// after reset the mirrors are zeroed entry by entry with s_axis_tready low
// a two-entry queue keeps taking requests while a result waits on m_axis_tready
`timescale 1ns / 1ps
`include "modbus_rtu_response_parser_defines.svh"
module modbus_rtu_response_parser #(
  parameter int MIRROR_DEPTH = mrp_pkg::MIRROR_DEPTH_DEF,
  parameter int MAX_FRAME    = mrp_pkg::MAX_FRAME_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // rx_byte[7:0], pending_func_code[15:8], pending_start[31:16],
  // pending_count[47:32], query_addr[63:48]
  input  logic [mrp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]                      s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // frame_status[2:0], slave_addr[10:3], func_seen[18:11], reg_value[34:19], zero pad
  output logic [mrp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // result_kind[0]
  output logic                            m_axis_tuser
);
  import mrp_pkg::*;

  cmd_t push_cmd, head;
  logic push, pop, q_full, q_empty, clr_busy;

  mrp_front #(.MIRROR_DEPTH(MIRROR_DEPTH)) u_front (
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .q_full_i(q_full), .clr_busy_i(clr_busy), .push_o(push), .cmd_o(push_cmd)
  );

  mrp_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(push_cmd), .full_o(q_full),
    .pop_i(pop), .head_o(head), .empty_o(q_empty)
  );

  mrp_back #(.MIRROR_DEPTH(MIRROR_DEPTH), .MAX_FRAME(MAX_FRAME)) u_back (
    .clk_i, .rst_ni, .head_i(head), .empty_i(q_empty), .pop_o(pop),
    .clr_busy_o(clr_busy), .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .m_axis_tuser
  );

  // checks
  `MRP_ASSERT_NOW(a_no_take_in_clear, clr_busy, !s_axis_tready, "request taken during clear")
  `MRP_ASSERT_NOW(a_no_pop_empty, pop, !q_empty, "pop from empty queue")
  `MRP_ASSERT_NOW(a_read_hdr_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[18:0] == 19'd0, "read result carries frame fields")
  `MRP_ASSERT_NEXT(a_push_full, q_full && !pop, !push, "push into full queue")

endmodule
